// ----- sv/word_prefix_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// word prefix matcher assertion macros
// shared concurrent assertion forms, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef WORD_PREFIX_MATCHER_ASSERT_SVH
`define WORD_PREFIX_MATCHER_ASSERT_SVH

// assertion that is off while reset is asserted
`define WPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that also holds during reset
`define WPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types, constants and register codes of the word prefix matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

    // defaults of the top level parameters
    localparam int MAX_PATTERN_DEF     = 5;
    localparam int WORD_COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int PATTERN_W     = 40;
    localparam int PATTERN_BYTES = 5;
    localparam int LENGTH_W      = 3;
    localparam int WORD_NUM_W    = 16;
    localparam int CFG_IDX_W     = 1;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // special characters
    localparam logic [7:0] APOSTROPHE = 8'h27;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

    // input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } in_t;

    // result beat
    typedef struct packed {
        logic                  out_kind;
        logic [7:0]            out_char;
        logic [WORD_NUM_W-1:0] word_number;
        logic                  last;
    } out_t;

    // job operations
    typedef enum logic {
        OP_CHARS = 1'b0,
        OP_CLOSE = 1'b1
    } job_op_t;

    // fixed part of a queued job
    typedef struct packed {
        job_op_t               op;
        logic [WORD_NUM_W-1:0] word_number;
    } job_t;

endpackage

// ----- sv/word_prefix_matcher.sv -----
// ----------------------------------------------------------------------------
// word_prefix_matcher
// case-insensitive word prefix search over a byte stream
// ----------------------------------------------------------------------------
// The block takes one text beat per cycle while its four-entry job queue has
// room. Each beat is classified in the cycle it is accepted; a beat that
// yields results queues one job. The output side sends one result beat per
// cycle while m_ready is high: a completed match sends the clamped pattern
// length in beats for a single input beat, any other job one beat, so the
// output serializer sets the sustained rate, and bursts of matches stall
// the input once the queue is full. Configuration is written through a
// plain write port and takes effect on the next beat.
module word_prefix_matcher #(
    parameter int MAX_PATTERN     = wpm_pkg::MAX_PATTERN_DEF,
    parameter int WORD_COUNT_BITS = wpm_pkg::WORD_COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [wpm_pkg::PATTERN_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wpm_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wpm_pkg::out_t                  m_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int JOB_W = $bits(wpm_pkg::job_t) + LEN_W + MAX_PATTERN * 8;

    logic             q_full;
    logic             q_push;
    logic [JOB_W-1:0] q_push_data;
    logic             q_pop;
    logic             q_valid;
    logic [JOB_W-1:0] q_head;

    // classifier
    wpm_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .WORD_COUNT_BITS (WORD_COUNT_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    // job queue
    wpm_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // output serializer
    wpm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- sv/wpm_front.sv -----
// ----------------------------------------------------------------------------
// wpm_front
// accepts text beats, tracks token and segment state and queues output jobs
// ----------------------------------------------------------------------------
module wpm_front #(
    parameter int MAX_PATTERN     = wpm_pkg::MAX_PATTERN_DEF,
    parameter int WORD_COUNT_BITS = wpm_pkg::WORD_COUNT_BITS_DEF,
    localparam int LEN_W = $clog2(MAX_PATTERN + 1),
    localparam int JOB_W = $bits(wpm_pkg::job_t) + LEN_W + MAX_PATTERN * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [wpm_pkg::PATTERN_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wpm_pkg::in_t                   s_data,
    input  logic                           q_full,
    output logic                           q_push,
    output logic [JOB_W-1:0]               q_data
);

    localparam int PAD_W = (MAX_PATTERN + wpm_pkg::PATTERN_BYTES) * 8;

    logic [wpm_pkg::PATTERN_W-1:0] pattern_chars_reg;
    logic [wpm_pkg::LENGTH_W-1:0]  pattern_length_reg;

    logic [LEN_W-1:0]           matched_count_reg, matched_count_next;
    logic                       seg_valid_reg, seg_valid_next;
    logic                       tok_ignored_reg, tok_ignored_next;
    logic                       in_token_reg, in_token_next;
    logic                       emitting_reg, emitting_next;
    logic [WORD_COUNT_BITS-1:0] word_cnt_reg, word_cnt_next;
    logic [7:0]                 prefix_buf_reg [MAX_PATTERN];

    logic                       accept;
    logic [7:0]                 c;
    logic [7:0]                 len_raw;
    logic [LEN_W-1:0]           eff_len;
    logic [LEN_W-1:0]           mc_plus;
    logic [PAD_W-1:0]           pat_padded;
    logic [7:0]                 pat_byte;
    logic [WORD_COUNT_BITS-1:0] word_cnt_bumped;
    logic [31:0]                word_cnt_wide;
    logic [MAX_PATTERN*8-1:0]   burst_chars;
    logic                       buf_we;
    logic                       is_alnum;
    logic                       is_space;

    wpm_pkg::job_t            job;
    logic [LEN_W-1:0]         job_count;
    logic [MAX_PATTERN*8-1:0] job_chars;

    function automatic logic [7:0] to_lower(input logic [7:0] ch);
        logic [7:0] r;
        r = ch;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            r = ch + 8'd32;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_chars_reg  <= '0;
            pattern_length_reg <= wpm_pkg::LENGTH_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                wpm_pkg::CFG_PATTERN_CHARS: begin
                    pattern_chars_reg <= cfg_wr_data;
                end
                wpm_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wr_data[wpm_pkg::LENGTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake and character classes
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.text_byte;

    assign is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                      (c >= 8'h61 && c <= 8'h7A);
    assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);

    // effective pattern length, clamped to one and to the buffer depth
    assign len_raw = 8'(pattern_length_reg);
    always_comb begin
        if (len_raw == 8'd0) begin
            eff_len = LEN_W'(1);
        end else if (len_raw > 8'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(len_raw);
        end
    end

    // pattern byte at the matched position, zero past the stored bytes
    assign pat_padded = {{(MAX_PATTERN * 8){1'b0}}, pattern_chars_reg};
    always_comb begin
        pat_byte = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (matched_count_reg == LEN_W'(i)) begin
                pat_byte = pat_padded[8*i +: 8];
            end
        end
    end

    // buffered prefix with the current byte in the matched slot
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (matched_count_reg == LEN_W'(i)) begin
                burst_chars[8*i +: 8] = c;
            end else begin
                burst_chars[8*i +: 8] = prefix_buf_reg[i];
            end
        end
    end

    assign mc_plus         = matched_count_reg + LEN_W'(1);
    assign word_cnt_bumped = (word_cnt_reg == '1) ? word_cnt_reg
                                                  : word_cnt_reg + WORD_COUNT_BITS'(1);
    assign word_cnt_wide   = 32'(word_cnt_reg);

    // token and segment tracking
    always_comb begin
        matched_count_next = matched_count_reg;
        seg_valid_next     = seg_valid_reg;
        tok_ignored_next   = tok_ignored_reg;
        in_token_next      = in_token_reg;
        emitting_next      = emitting_reg;
        word_cnt_next      = word_cnt_reg;
        buf_we             = 1'b0;
        q_push             = 1'b0;
        job.op             = wpm_pkg::OP_CLOSE;
        job.word_number    = word_cnt_wide[wpm_pkg::WORD_NUM_W-1:0];
        job_count          = LEN_W'(1);
        job_chars          = {{((MAX_PATTERN - 1) * 8){1'b0}}, c};

        if (accept) begin
            if (s_data.kind) begin
                // end of text: flush and restart numbering
                q_push             = emitting_reg;
                emitting_next      = 1'b0;
                in_token_next      = 1'b0;
                tok_ignored_next   = 1'b0;
                seg_valid_next     = 1'b1;
                matched_count_next = '0;
                word_cnt_next      = WORD_COUNT_BITS'(1);
            end else if (is_space) begin
                q_push             = emitting_reg;
                emitting_next      = 1'b0;
                if (in_token_reg) begin
                    word_cnt_next = word_cnt_bumped;
                end
                in_token_next      = 1'b0;
                tok_ignored_next   = 1'b0;
                seg_valid_next     = 1'b1;
                matched_count_next = '0;
            end else begin
                in_token_next = 1'b1;
                if (tok_ignored_reg) begin
                    // rest of token ignored
                end else if (is_alnum) begin
                    if (emitting_reg) begin
                        q_push = 1'b1;
                        job.op = wpm_pkg::OP_CHARS;
                    end else if (seg_valid_reg) begin
                        if (matched_count_reg < eff_len &&
                            to_lower(pat_byte) == to_lower(c)) begin
                            buf_we             = 1'b1;
                            matched_count_next = mc_plus;
                            if (mc_plus == eff_len) begin
                                q_push         = 1'b1;
                                job.op         = wpm_pkg::OP_CHARS;
                                job_count      = eff_len;
                                job_chars      = burst_chars;
                                emitting_next  = 1'b1;
                                seg_valid_next = 1'b0;
                            end
                        end else begin
                            seg_valid_next = 1'b0;
                        end
                    end
                end else if (c == wpm_pkg::APOSTROPHE) begin
                    // apostrophe opens a new segment and a new word
                    q_push             = emitting_reg;
                    emitting_next      = 1'b0;
                    matched_count_next = '0;
                    seg_valid_next     = 1'b1;
                    word_cnt_next      = word_cnt_bumped;
                end else begin
                    q_push           = emitting_reg;
                    emitting_next    = 1'b0;
                    tok_ignored_next = 1'b1;
                end
            end
        end
    end

    assign q_data = {job, job_count, job_chars};

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matched_count_reg <= '0;
            seg_valid_reg     <= 1'b1;
            tok_ignored_reg   <= 1'b0;
            in_token_reg      <= 1'b0;
            emitting_reg      <= 1'b0;
            word_cnt_reg      <= WORD_COUNT_BITS'(1);
        end else begin
            matched_count_reg <= matched_count_next;
            seg_valid_reg     <= seg_valid_next;
            tok_ignored_reg   <= tok_ignored_next;
            in_token_reg      <= in_token_next;
            emitting_reg      <= emitting_next;
            word_cnt_reg      <= word_cnt_next;
        end
    end

    // prefix buffer, one slot written per matched byte
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (buf_we && matched_count_reg == LEN_W'(i)) begin
                prefix_buf_reg[i] <= c;
            end
        end
    end

endmodule

// ----- sv/wpm_queue.sv -----
// ----------------------------------------------------------------------------
// wpm_queue
// small job queue that decouples the front end from the output serializer
// ----------------------------------------------------------------------------
`include "word_prefix_matcher_assert.svh"

module wpm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int DEPTH = wpm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // front never writes a full queue, back never reads an empty one
    `WPM_ASSERT(a_no_overflow, aclk, aresetn, push |-> !full, "job queue overflow")
    `WPM_ASSERT(a_no_underflow, aclk, aresetn, pop |-> head_valid, "job queue underflow")
    `WPM_ASSERT(a_count_up, aclk, aresetn, (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1), "queue count did not rise")

endmodule

// ----- sv/wpm_back.sv -----
// ----------------------------------------------------------------------------
// wpm_back
// takes queued jobs and sends their result beats one per cycle while m_ready is high
// ----------------------------------------------------------------------------
module wpm_back #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
    localparam int LEN_W = $clog2(MAX_PATTERN + 1),
    localparam int JOB_W = $bits(wpm_pkg::job_t) + LEN_W + MAX_PATTERN * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  logic [JOB_W-1:0]   q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output wpm_pkg::out_t      m_data
);

    logic                     cur_valid_reg;
    logic [JOB_W-1:0]         cur_job_reg;
    logic [LEN_W-1:0]         idx_reg;

    wpm_pkg::job_t            job;
    logic [LEN_W-1:0]         job_count;
    logic [MAX_PATTERN*8-1:0] job_chars;
    logic [7:0]               sel_char;
    logic                     is_close;
    logic                     last_beat;
    logic                     beat_done;

    assign {job, job_count, job_chars} = cur_job_reg;

    // character at the current position of the burst
    always_comb begin
        sel_char = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (idx_reg == LEN_W'(i)) begin
                sel_char = job_chars[8*i +: 8];
            end
        end
    end

    assign is_close  = (job.op == wpm_pkg::OP_CLOSE);
    assign last_beat = is_close || (idx_reg + LEN_W'(1) == job_count);
    assign beat_done = cur_valid_reg && m_ready;
    assign q_pop     = q_valid && (!cur_valid_reg || (beat_done && last_beat));

    // result beat
    assign m_valid            = cur_valid_reg;
    assign m_data.out_kind    = is_close;
    assign m_data.out_char    = is_close ? 8'd0 : sel_char;
    assign m_data.word_number = is_close ? job.word_number : '0;
    assign m_data.last        = last_beat;

    // job register and beat position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (beat_done) begin
                if (last_beat) begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= '0;
                end else begin
                    idx_reg <= idx_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_job_reg <= q_data;
        end
    end

endmodule

// ----- bench/tb_word_prefix_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_word_prefix_matcher
// self-checking bench for the case-insensitive word prefix matcher
// ----------------------------------------------------------------------------
// Text beats go in through the input channel. A behavioral predictor inside
// the bench tracks token, segment and match state and queues the result beats
// each accepted beat should cause. A monitor compares every result beat with
// the oldest queued one, field by field. Directed tests cover matching,
// apostrophe segments, ignored tokens, length corner cases, a length change
// inside a segment, word numbering across apostrophes and output
// back-pressure. Random text with idle gaps on both sides follows.
// ----------------------------------------------------------------------------
module tb_word_prefix_matcher;

    localparam int         SETTLE_CYCLES = 12;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [wpm_pkg::CFG_IDX_W-1:0] cfg_wr_index;
    logic [wpm_pkg::PATTERN_W-1:0] cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    wpm_pkg::in_t                  s_data;
    logic                          m_valid;
    logic                          m_ready;
    wpm_pkg::out_t                 m_data;

    // predictor copy of the configuration and of the matcher state
    logic [wpm_pkg::PATTERN_W-1:0]  cur_pattern = '0;
    logic [wpm_pkg::LENGTH_W-1:0]   cur_length  = 3'd1;
    int unsigned                    match_len   = 0;
    logic                           seg_open    = 1'b1;
    logic                           token_skip  = 1'b0;
    logic                           token_open  = 1'b0;
    logic                           run_open    = 1'b0;
    logic [wpm_pkg::WORD_NUM_W-1:0] word_no     = 16'd1;
    logic [7:0]                     prefix_seen [wpm_pkg::PATTERN_BYTES];

    // result beats still owed by the block, oldest first
    wpm_pkg::out_t expected_beats [$];

    int error_count       = 0;
    int beats_sent        = 0;
    int src_gap_pct       = 0;
    int sink_stall_pct    = 0;
    int sink_hold_request = 0;

    word_prefix_matcher uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // out of range lengths clamp to 1..PATTERN_BYTES
    function automatic int active_length();
        if (cur_length == 0) begin
            return 1;
        end
        if (cur_length > wpm_pkg::PATTERN_BYTES) begin
            return wpm_pkg::PATTERN_BYTES;
        end
        return int'(cur_length);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        wpm_pkg::out_t r;
        r = '0;
        r.out_char = c;
        expected_beats.push_back(r);
    endfunction

    // end an open match run with its word number
    function automatic void close_run();
        wpm_pkg::out_t r;
        if (run_open) begin
            r = '0;
            r.out_kind = 1'b1;
            r.word_number = word_no;
            expected_beats.push_back(r);
            run_open = 1'b0;
        end
    endfunction

    function automatic void bump_word();
        if (word_no != '1) begin
            word_no++;
        end
    endfunction

    function automatic void clear_token();
        token_open = 1'b0;
        token_skip = 1'b0;
        seg_open   = 1'b1;
        match_len  = 0;
    endfunction

    function automatic void predict_beat(input wpm_pkg::in_t beat);
        int            prior_size;
        int            n;
        int            i;
        wpm_pkg::out_t r;
        logic [7:0]    c;
        prior_size = expected_beats.size();
        c = beat.text_byte;
        n = active_length();
        if (beat.kind) begin
            // end of text: flush and restart numbering
            close_run();
            clear_token();
            word_no = 16'd1;
        end else if (is_space(c)) begin
            close_run();
            if (token_open) begin
                bump_word();
            end
            clear_token();
        end else begin
            token_open = 1'b1;
            if (token_skip) begin
                // rest of token ignored
            end else if (is_alnum(c)) begin
                if (run_open) begin
                    push_char(c);
                end else if (seg_open) begin
                    if (match_len < n &&
                        fold_case(cur_pattern[8*match_len +: 8]) == fold_case(c)) begin
                        prefix_seen[match_len] = c;
                        match_len++;
                        if (match_len == n) begin
                            for (i = 0; i < n; i++) begin
                                push_char(prefix_seen[i]);
                            end
                            run_open = 1'b1;
                            seg_open = 1'b0;
                        end
                    end else begin
                        seg_open = 1'b0;
                    end
                end
            end else if (c == wpm_pkg::APOSTROPHE) begin
                // new segment, new word
                close_run();
                match_len = 0;
                seg_open  = 1'b1;
                bump_word();
            end else begin
                close_run();
                token_skip = 1'b1;
            end
        end
        // flag the final result of this beat
        if (expected_beats.size() > prior_size) begin
            r = expected_beats.pop_back();
            r.last = 1'b1;
            expected_beats.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        wpm_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing, actual %h",
                         $time, m_data);
                error_count++;
            end else begin
                want = expected_beats.pop_front();
                compare_field("out_kind", 16'(want.out_kind), 16'(m_data.out_kind));
                compare_field("out_char", 16'(want.out_char), 16'(m_data.out_char));
                compare_field("word_number", want.word_number, m_data.word_number);
                compare_field("last", 16'(want.last), 16'(m_data.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // idle gaps and receiver stalls
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(20, 6);
        end
        return $urandom_range(3, 1);
    endfunction

    // receiver: random stalls, or one long hold when a test asks for it
    initial begin : result_sink
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_request > 0) begin
                hold = sink_hold_request;
                sink_hold_request = 0;
            end else if (hold == 0 && $urandom_range(99) < sink_stall_pct) begin
                hold = pick_gap(100);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // offer one beat, hold it until accepted, then predict its results
    task automatic push_beat(input wpm_pkg::in_t beat);
        int gap;
        gap = pick_gap(src_gap_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(beat);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        wpm_pkg::in_t beat;
        beat.kind = 1'b0;
        beat.text_byte = c;
        push_beat(beat);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_end();
        wpm_pkg::in_t beat;
        beat.kind = 1'b1;
        beat.text_byte = 8'($urandom_range(255));
        push_beat(beat);
    endtask

    // wait until every owed result is out and the block has settled
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write both registers back to back; only called while idle
    task automatic load_config(input logic [wpm_pkg::PATTERN_W-1:0] pattern,
                               input logic [wpm_pkg::LENGTH_W-1:0] len);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= wpm_pkg::CFG_PATTERN_CHARS;
        cfg_wr_data  <= pattern;
        @(posedge aclk);
        cur_pattern = pattern;
        cfg_wr_index <= wpm_pkg::CFG_PATTERN_LENGTH;
        cfg_wr_data  <= wpm_pkg::PATTERN_W'(len);
        @(posedge aclk);
        cur_length = len;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [wpm_pkg::PATTERN_W-1:0] pack_pattern(input string s);
        logic [wpm_pkg::PATTERN_W-1:0] p;
        int                            i;
        p = '0;
        for (i = 0; i < s.len() && i < wpm_pkg::PATTERN_BYTES; i++) begin
            p[8*i +: 8] = s[i];
        end
        return p;
    endfunction

    function automatic logic [7:0] random_alnum();
        int k;
        k = $urandom_range(61);
        if (k < 10) begin
            return 8'(48 + k);
        end
        if (k < 36) begin
            return 8'(65 + k - 10);
        end
        return 8'(97 + k - 36);
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [wpm_pkg::PATTERN_W-1:0] random_pattern();
        logic [wpm_pkg::PATTERN_W-1:0] p;
        int                            i;
        for (i = 0; i < wpm_pkg::PATTERN_BYTES; i++) begin
            p[8*i +: 8] = random_alnum();
        end
        return p;
    endfunction

    // mostly words that start with all or part of the pattern, plus noise
    task automatic run_random_text(input int n_items);
        int stop_at;
        int pick;
        int k;
        int i;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                k = ($urandom_range(1) == 1) ? active_length() : $urandom_range(active_length());
                for (i = 0; i < k; i++) begin
                    send_byte(flip_case(cur_pattern[8*i +: 8]));
                end
                k = $urandom_range(4);
                for (i = 0; i < k; i++) begin
                    send_byte(random_alnum());
                end
            end else if (pick < 75) begin
                send_byte(($urandom_range(1) == 1) ? CHAR_SPACE : 8'($urandom_range(13, 9)));
            end else if (pick < 85) begin
                send_byte(wpm_pkg::APOSTROPHE);
            end else if (pick < 96) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_end();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // matches in mixed case, apostrophe segments, ignored tokens, end of text
    task automatic test_basic_words();
        src_gap_pct = 20;
        sink_stall_pct = 20;
        load_config(pack_pattern("Ab"), 3'd2);
        send_text("aBcd xab'AB1-ab\t'ab9 ");
        send_text("ab");
        send_end();
        wait_until_idle();
    endtask

    // odd pattern bytes, out of range lengths, extreme text bytes
    task automatic test_length_extremes();
        load_config('1, 3'd7);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_text("a7 ");
        wait_until_idle();
        load_config(pack_pattern("z"), 3'd0);
        send_text("Zz9 z");
        send_end();
        wait_until_idle();
        load_config(pack_pattern("12345"), 3'd5);
        send_text("123456 1234 ");
        wait_until_idle();
        load_config(pack_pattern("a-"), 3'd2);
        send_text("a- a-b");
        send_byte(8'h0B);
        wait_until_idle();
        load_config(pack_pattern("Qq"), 3'd6);
        send_text("qQ ");
        wait_until_idle();
    endtask

    // length rewritten while a segment is partly matched
    task automatic test_length_change();
        load_config(pack_pattern("abc"), 3'd3);
        send_text("ab");
        wait_until_idle();
        load_config(pack_pattern("abc"), 3'd2);
        send_text("c ab a");
        wait_until_idle();
        load_config(pack_pattern("abc"), 3'd3);
        send_text("bC ");
        wait_until_idle();
    endtask

    // apostrophes bump the word number at every new segment
    task automatic test_word_counter();
        int i;
        src_gap_pct = 0;
        sink_stall_pct = 0;
        load_config(pack_pattern("ab"), 3'd2);
        send_text("ab");
        for (i = 0; i < 30; i++) begin
            send_byte(wpm_pkg::APOSTROPHE);
        end
        send_text("ab ab");
        send_end();
        send_text("ab ");
        wait_until_idle();
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        int i;
        src_gap_pct = 0;
        sink_stall_pct = 0;
        load_config(pack_pattern("wx"), 3'd2);
        sink_hold_request = 80;
        for (i = 0; i < 12; i++) begin
            send_text("WxYz ");
        end
        wait_until_idle();
    endtask

    // random text over several settings and idle profiles
    task automatic test_random_traffic();
        int                           phase;
        int                           gap_mix   [4] = '{30, 0, 60, 10};
        int                           stall_mix [4] = '{30, 0, 10, 60};
        logic [wpm_pkg::LENGTH_W-1:0] len;
        for (phase = 0; phase < 4; phase++) begin
            if (phase == 2) begin
                len = 3'd1;
            end else if (phase == 3) begin
                len = 3'd5;
            end else begin
                len = 3'($urandom_range(5, 1));
            end
            load_config(random_pattern(), len);
            src_gap_pct = gap_mix[phase];
            sink_stall_pct = stall_mix[phase];
            run_random_text(28);
            wait_until_idle();
        end
    endtask

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_words();
        test_length_extremes();
        test_length_change();
        test_word_counter();
        test_backpressure();
        test_random_traffic();

        wait_until_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(64'd20_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
